/* sv/sacl_pkg.sv */
package sacl_pkg;

    // Default sizes of the storage.
    localparam int MAX_WAYS_DEF  = 8;
    localparam int MAX_SETS_DEF  = 64;
    localparam int ADDR_BITS_DEF = 32;

    // Fixed widths of the configuration registers and the result fields.
    localparam int WAYS_CFG_W   = 4;
    localparam int SETB_CFG_W   = 3;
    localparam int OFFS_CFG_W   = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int TAG_W        = 32;
    localparam int BLOCK_W      = 32;
    localparam int SET_OUT_W    = 6;
    localparam int WAY_OUT_W    = 3;

    // Reset values of the configuration registers.
    localparam logic [WAYS_CFG_W-1:0] WAYS_RST = WAYS_CFG_W'(2);
    localparam logic [SETB_CFG_W-1:0] SETB_RST = SETB_CFG_W'(2);
    localparam logic [OFFS_CFG_W-1:0] OFFS_RST = OFFS_CFG_W'(3);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } t_status;

endpackage

/* sv/set_assoc_cache_fifo_lookup.sv */
// Set-associative cache tag lookup with FIFO replacement.
// Input channel: i_valid with o_stall carries one byte address per transfer.
// Output channel: o_valid with i_stall carries hit, block number, tag, set
// index, way and an eviction flag for every address, in order.
// Configuration: i_cfg_we writes i_cfg_data into the register chosen by
// i_cfg_idx (0 ways in use, 1 set bits, 2 offset bits); write only when idle.
// An address is taken in S_IDLE while its set row is read into registers; in
// S_LOOK, once the result register is free, the tags are compared, the set is
// updated and the result register is loaded. No new address is taken until
// that row update is done, as the controller accepts only in S_IDLE.
// After reset the block clears the valid bits and FIFO pointers of every set
// in turn, with o_stall high; configuration writes are still taken.
// A stalled result stays in the output register; one further address may be
// taken behind it, and its update waits until the result has been moved.
module set_assoc_cache_fifo_lookup #(
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
    parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ADDR_BITS-1:0]              i_address,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic [sacl_pkg::BLOCK_W-1:0]      o_block_number,
    output logic [sacl_pkg::TAG_W-1:0]        o_tag_value,
    output logic [sacl_pkg::SET_OUT_W-1:0]    o_set_index,
    output logic [sacl_pkg::WAY_OUT_W-1:0]    o_way,
    output logic                              o_evicted
);

    sacl_pkg::t_cmd    cmd;
    sacl_pkg::t_status status;

    sacl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    sacl_datapath #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_address      (i_address),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_block_number (o_block_number),
        .o_tag_value    (o_tag_value),
        .o_set_index    (o_set_index),
        .o_way          (o_way),
        .o_evicted      (o_evicted)
    );

endmodule

/* sv/sacl_ctrl.sv */
module sacl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sacl_pkg::t_status i_status,
    output sacl_pkg::t_cmd    o_cmd,
    output logic              o_stall
);

    sacl_pkg::t_state r_state;
    sacl_pkg::t_state n_state;
    logic             accept;

    assign accept  = i_valid && (r_state == sacl_pkg::S_IDLE);
    assign o_stall = (r_state != sacl_pkg::S_IDLE);

    always_comb begin
        o_cmd.clear  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        n_state      = r_state;
        case (r_state)
            sacl_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = sacl_pkg::S_IDLE;
                end
            end
            sacl_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = sacl_pkg::S_LOOK;
                end
            end
            sacl_pkg::S_LOOK: begin
                // The result register must be free before the set is updated.
                if (!i_status.out_blocked) begin
                    o_cmd.update = 1'b1;
                    n_state      = sacl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sacl_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/sacl_datapath.sv */
module sacl_datapath #(
    parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
    parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sacl_pkg::t_cmd                    i_cmd,
    output sacl_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [ADDR_BITS-1:0]              i_address,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic [sacl_pkg::BLOCK_W-1:0]      o_block_number,
    output logic [sacl_pkg::TAG_W-1:0]        o_tag_value,
    output logic [sacl_pkg::SET_OUT_W-1:0]    o_set_index,
    output logic [sacl_pkg::WAY_OUT_W-1:0]    o_way,
    output logic                              o_evicted
);

    localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int KW     = $clog2(MAX_WAYS + 1);
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int TAG_W  = sacl_pkg::TAG_W;

    // Configuration registers.
    logic [sacl_pkg::WAYS_CFG_W-1:0] r_ways;
    logic [sacl_pkg::SETB_CFG_W-1:0] r_set_bits;
    logic [sacl_pkg::OFFS_CFG_W-1:0] r_offset_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways        <= sacl_pkg::WAYS_RST;
            r_set_bits    <= sacl_pkg::SETB_RST;
            r_offset_bits <= sacl_pkg::OFFS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sacl_pkg::CFG_WAYS_IN_USE: r_ways        <= i_cfg_data[sacl_pkg::WAYS_CFG_W-1:0];
                sacl_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_data[sacl_pkg::SETB_CFG_W-1:0];
                sacl_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[sacl_pkg::OFFS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective associativity and set bits, saturated to the storage; zero ways counts as one.
    logic [KW-1:0]                   k_eff;
    logic [sacl_pkg::SETB_CFG_W-1:0] sb_eff;

    always_comb begin
        if (r_ways == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            k_eff = KW'(MAX_WAYS);
        end else begin
            k_eff = KW'(r_ways);
        end
        if (32'(r_set_bits) > SB_MAX) begin
            sb_eff = sacl_pkg::SETB_CFG_W'(SB_MAX);
        end else begin
            sb_eff = r_set_bits;
        end
    end

    // Address split for the incoming item.
    logic [ADDR_BITS-1:0] blk;
    logic [ADDR_BITS-1:0] tag_full;
    logic [63:0]          blk64;
    logic [63:0]          tag64;
    logic [SET_AW-1:0]    set_in;

    assign blk      = i_address >> r_offset_bits;
    assign tag_full = blk >> sb_eff;
    assign blk64    = 64'(blk);
    assign tag64    = 64'(tag_full);
    assign set_in   = blk64[SET_AW-1:0] & ~({SET_AW{1'b1}} << sb_eff);

    logic [sacl_pkg::BLOCK_W-1:0] r_block;
    logic [TAG_W-1:0]             r_tag;
    logic [SET_AW-1:0]            r_set;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_block <= blk64[sacl_pkg::BLOCK_W-1:0];
            r_tag   <= tag64[TAG_W-1:0];
            r_set   <= set_in;
        end
    end

    // Clearing pass over the valid bits and FIFO pointers after reset.
    logic [SET_AW-1:0] r_clr_addr;
    logic              clr_last;

    assign clr_last = (r_clr_addr == SET_AW'(MAX_SETS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !clr_last) begin
            r_clr_addr <= r_clr_addr + SET_AW'(1);
        end
    end

    // Set storage: one row per set.
    logic [MAX_WAYS-1:0]            mem_valid [MAX_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0] mem_tag   [MAX_SETS];
    logic [WAY_W-1:0]               mem_fifo  [MAX_SETS];

    logic [MAX_WAYS-1:0]            r_rd_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0] r_rd_tag;
    logic [WAY_W-1:0]               r_rd_fifo;

    // Lookup on the row read for the held item.
    logic             hit;
    logic             free_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] fifo_nxt;
    logic [WAY_W-1:0] sel_way;
    logic             evict;

    always_comb begin
        hit        = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w < 32'(k_eff)) begin
                if (r_rd_valid[w] && (r_rd_tag[w] == r_tag)) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!r_rd_valid[w]) begin
                    free_found = 1'b1;
                    free_way   = WAY_W'(w);
                end
            end
        end
        // A pointer left stale by a smaller associativity falls back to way 0.
        if (32'(r_rd_fifo) >= 32'(k_eff)) begin
            victim = '0;
        end else begin
            victim = r_rd_fifo;
        end
        if (32'(victim) + 1 == 32'(k_eff)) begin
            fifo_nxt = '0;
        end else begin
            fifo_nxt = victim + WAY_W'(1);
        end
        evict = !hit && !free_found;
        if (hit) begin
            sel_way = hit_way;
        end else if (free_found) begin
            sel_way = free_way;
        end else begin
            sel_way = victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_valid[r_clr_addr] <= '0;
        end else if (i_cmd.update && !hit) begin
            mem_valid[r_set] <= r_rd_valid | (MAX_WAYS'(1) << sel_way);
        end
        if (i_cmd.load) begin
            r_rd_valid <= mem_valid[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !hit) begin
            mem_tag[r_set][sel_way] <= r_tag;
        end
        if (i_cmd.load) begin
            r_rd_tag <= mem_tag[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_fifo[r_clr_addr] <= '0;
        end else if (i_cmd.update && evict) begin
            mem_fifo[r_set] <= fifo_nxt;
        end
        if (i_cmd.load) begin
            r_rd_fifo <= mem_fifo[set_in];
        end
    end

    // Result register.
    logic        r_out_valid;
    logic [15:0] set16;
    logic [15:0] way16;

    assign set16 = 16'(r_set);
    assign way16 = 16'(sel_way);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_hit          <= hit;
            o_block_number <= r_block;
            o_tag_value    <= r_tag;
            o_set_index    <= set16[sacl_pkg::SET_OUT_W-1:0];
            o_way          <= way16[sacl_pkg::WAY_OUT_W-1:0];
            o_evicted      <= evict;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status.clear_last  = clr_last;
    assign o_status.out_blocked = r_out_valid && i_stall;

endmodule
